### hdl/assert_macros.svh
// Assertion macros shared by the grid cell enumeration RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hdl/gcbb_pkg.sv
// Shared types and constants for the grid cell enumeration unit.
package gcbb_pkg;

  localparam int MAX_CELLS_PER_DIM = 8;
  localparam int IDX_W   = 3;
  localparam int CPD_W   = 4;
  localparam int ID_W    = 6;
  localparam int STAT_W  = 2;
  localparam int COORD_W = 32;
  localparam int SIZE_W  = 31;
  localparam int QDEPTH  = 2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_OUTSIDE = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;

  localparam logic [2:0] CFG_ORIGIN_X      = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y      = 3'd1;
  localparam logic [2:0] CFG_CELL_WIDTH    = 3'd2;
  localparam logic [2:0] CFG_CELL_HEIGHT   = 3'd3;
  localparam logic [2:0] CFG_CELLS_PER_DIM = 3'd4;

  typedef struct packed {
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [SIZE_W-1:0]  cell_width;
    logic [SIZE_W-1:0]  cell_height;
    logic [CPD_W-1:0]   cells_per_dim;
  } gcbb_cfg_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  col_lo;
    logic [IDX_W-1:0]  col_hi;
    logic [IDX_W-1:0]  row_lo;
    logic [IDX_W-1:0]  row_hi;
    logic [CPD_W-1:0]  cpd;
  } gcbb_desc_t;

endpackage

### hdl/grid_cells_for_bounding_box_unit.sv
// The front runs 3 restoring divide steps on four lanes and takes no new box
// until it has pushed the last; the back sends one result per cycle while its
// output is free or popped: one per covered cell, one for an error box.
// A two-entry queue lets the front classify the next box while cells stream.
// Reset: synchronous active-low; clears control and restores config defaults.
`include "assert_macros.svh"

module grid_cells_for_bounding_box_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] in_box_min_x,
  input  logic signed [31:0] in_box_min_y,
  input  logic signed [31:0] in_box_max_x,
  input  logic signed [31:0] in_box_max_y,
  output logic               empty,
  input  logic               pop,
  output logic [5:0]         out_cell_id,
  output logic [1:0]         out_status,
  output logic               out_last
);
  import gcbb_pkg::*;

  gcbb_cfg_t  cfg_r;
  gcbb_desc_t fq_wdata;
  gcbb_desc_t fq_rdata;
  logic       fq_push;
  logic       fq_full;
  logic       fq_pop;
  logic       fq_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x      <= '0;
      cfg_r.origin_y      <= '0;
      cfg_r.cell_width    <= SIZE_W'(65536);
      cfg_r.cell_height   <= SIZE_W'(65536);
      cfg_r.cells_per_dim <= CPD_W'(MAX_CELLS_PER_DIM);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIGIN_X:      cfg_r.origin_x      <= cfg_wdata;
        CFG_ORIGIN_Y:      cfg_r.origin_y      <= cfg_wdata;
        CFG_CELL_WIDTH:    cfg_r.cell_width    <= cfg_wdata[SIZE_W-1:0];
        CFG_CELL_HEIGHT:   cfg_r.cell_height   <= cfg_wdata[SIZE_W-1:0];
        CFG_CELLS_PER_DIM: cfg_r.cells_per_dim <= cfg_wdata[CPD_W-1:0];
        default: ;
      endcase
    end
  end

  gcbb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .push         (push),
    .full         (full),
    .in_box_min_x (in_box_min_x),
    .in_box_min_y (in_box_min_y),
    .in_box_max_x (in_box_max_x),
    .in_box_max_y (in_box_max_y),
    .q_push       (fq_push),
    .q_data       (fq_wdata),
    .q_full       (fq_full)
  );

  gcbb_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fq_push),
    .wr_data (fq_wdata),
    .q_full  (fq_full),
    .rd_en   (fq_pop),
    .rd_data (fq_rdata),
    .q_empty (fq_empty)
  );

  gcbb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_data      (fq_rdata),
    .q_empty     (fq_empty),
    .q_pop       (fq_pop),
    .empty       (empty),
    .pop         (pop),
    .out_cell_id (out_cell_id),
    .out_status  (out_status),
    .out_last    (out_last)
  );

  `ASSERT_IMPLY(a_err_single, clk, rst_n, !empty && out_status != ST_OK, out_last && out_cell_id == 6'd0, "error result not single")

endmodule

### hdl/gcbb_fifo.sv
// Two-entry descriptor queue between the classify front and the emit back.
`include "assert_macros.svh"

module gcbb_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  gcbb_pkg::gcbb_desc_t wr_data,
  output logic                q_full,
  input  logic                rd_en,
  output gcbb_pkg::gcbb_desc_t rd_data,
  output logic                q_empty
);
  import gcbb_pkg::*;

  gcbb_desc_t  mem_r [QDEPTH];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;
  logic        do_wr;
  logic        do_rd;

  assign q_full  = (cnt_r == 2'(QDEPTH));
  assign q_empty = (cnt_r == 2'd0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_rd) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= 2'(QDEPTH), "queue count above depth")

endmodule

### hdl/gcbb_front.sv
// Front: accepts a box, finds the four axis indices and classifies the box.
module gcbb_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gcbb_pkg::gcbb_cfg_t        cfg,
  input  logic                       push,
  output logic                       full,
  input  logic signed [31:0]         in_box_min_x,
  input  logic signed [31:0]         in_box_min_y,
  input  logic signed [31:0]         in_box_max_x,
  input  logic signed [31:0]         in_box_max_y,
  output logic                       q_push,
  output gcbb_pkg::gcbb_desc_t       q_data,
  input  logic                       q_full
);
  import gcbb_pkg::*;

  localparam int NLANE = 4;

  localparam logic [1:0] F_IDLE  = 2'd0;
  localparam logic [1:0] F_CHECK = 2'd1;
  localparam logic [1:0] F_DIV   = 2'd2;
  localparam logic [1:0] F_PUSH  = 2'd3;

  logic [1:0]       state_r;
  logic [1:0]       state_nxt;
  logic [1:0]       step_r;
  logic [32:0]      off_r  [NLANE];
  logic [31:0]      rem_r  [NLANE];
  logic [IDX_W-1:0] q_r    [NLANE];
  logic [NLANE-1:0] bad_r;
  logic [CPD_W-1:0] cpd_r;

  logic [31:0]      coord     [NLANE];
  logic [31:0]      lane_org  [NLANE];
  logic [SIZE_W-1:0] lane_size [NLANE];
  logic [32:0]      off_nxt   [NLANE];
  logic [NLANE-1:0] bad_nxt;
  logic [33:0]      dvs       [NLANE];
  logic [33:0]      diff      [NLANE];
  logic [33:0]      lo_sum    [NLANE];
  logic [NLANE-1:0] lane_ok;
  logic             accept;

  assign full   = (state_r != F_IDLE);
  assign accept = push && !full;

  assign coord[0] = in_box_min_x;
  assign coord[1] = in_box_min_y;
  assign coord[2] = in_box_max_x;
  assign coord[3] = in_box_max_y;

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      lane_org[i]  = i[0] ? cfg.origin_y : cfg.origin_x;
      lane_size[i] = i[0] ? cfg.cell_height : cfg.cell_width;
      off_nxt[i]   = {coord[i][31], coord[i]} - {lane_org[i][31], lane_org[i]};
      lo_sum[i]    = {off_r[i][32], off_r[i]} + {3'b000, lane_size[i]};
      bad_nxt[i]   = off_r[i][32] ? (lo_sum[i][33] || (lo_sum[i] == 34'd0))
                                  : ({1'b0, off_r[i]} >= {lane_size[i], 3'b000});
      dvs[i]       = {3'b000, lane_size[i]} << step_r;
      diff[i]      = {2'b00, rem_r[i]} - dvs[i];
      lane_ok[i]   = !bad_r[i] && ({1'b0, q_r[i]} < cpd_r);
    end
  end

  always_comb begin
    q_data        = '0;
    q_data.cpd    = cpd_r;
    q_data.col_lo = q_r[0];
    q_data.row_lo = q_r[1];
    q_data.col_hi = q_r[2];
    q_data.row_hi = q_r[3];
    if (!(&lane_ok)) begin
      q_data.status = ST_OUTSIDE;
    end else if ((q_r[0] > q_r[2]) || (q_r[1] > q_r[3])) begin
      q_data.status = ST_EMPTY;
    end else begin
      q_data.status = ST_OK;
    end
  end

  assign q_push = (state_r == F_PUSH);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:  if (accept) state_nxt = F_CHECK;
      F_CHECK: state_nxt = F_DIV;
      F_DIV:   if (step_r == 2'd0) state_nxt = F_PUSH;
      F_PUSH:  if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cpd_r <= (cfg.cells_per_dim > CPD_W'(MAX_CELLS_PER_DIM)) ?
               CPD_W'(MAX_CELLS_PER_DIM) : cfg.cells_per_dim;
      for (int i = 0; i < NLANE; i++) begin
        off_r[i] <= off_nxt[i];
      end
    end
    if (state_r == F_CHECK) begin
      step_r <= 2'(IDX_W - 1);
      bad_r  <= bad_nxt;
      for (int i = 0; i < NLANE; i++) begin
        rem_r[i] <= off_r[i][32] ? 32'd0 : off_r[i][31:0];
        q_r[i]   <= '0;
      end
    end
    if (state_r == F_DIV) begin
      step_r <= step_r - 2'd1;
      for (int i = 0; i < NLANE; i++) begin
        if (!diff[i][33]) begin
          rem_r[i]         <= diff[i][31:0];
          q_r[i][step_r]   <= 1'b1;
        end
      end
    end
  end

endmodule

### hdl/gcbb_back.sv
// Back: walks the covered cells of each descriptor, or one error result, into the result register.
`include "assert_macros.svh"

module gcbb_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gcbb_pkg::gcbb_desc_t q_data,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 empty,
  input  logic                 pop,
  output logic [5:0]           out_cell_id,
  output logic [1:0]           out_status,
  output logic                 out_last
);
  import gcbb_pkg::*;

  gcbb_desc_t       desc_r;
  logic             busy_r;
  logic [IDX_W-1:0] c_r;
  logic [IDX_W-1:0] r_r;
  logic             out_valid_r;
  logic [ID_W-1:0]  id_r;
  logic [STAT_W-1:0] stat_r;
  logic             last_r;

  logic             slot_free;
  logic             emit;
  logic             is_last;
  logic [ID_W-1:0]  prod;
  logic [ID_W-1:0]  id_nxt;

  assign slot_free = !out_valid_r || pop;
  assign emit      = busy_r && slot_free;
  assign q_pop     = !busy_r && !q_empty;
  assign is_last   = (desc_r.status != ST_OK) ||
                     ((c_r == desc_r.col_hi) && (r_r == desc_r.row_hi));
  assign prod      = ID_W'(r_r) * ID_W'(desc_r.cpd);
  assign id_nxt    = (desc_r.status != ST_OK) ? '0 : ({3'b000, c_r} + prod);

  assign empty       = !out_valid_r;
  assign out_cell_id = id_r;
  assign out_status  = stat_r;
  assign out_last    = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
      end else if (emit && is_last) begin
        busy_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      desc_r <= q_data;
      c_r    <= q_data.col_lo;
      r_r    <= q_data.row_lo;
    end else if (emit && !is_last) begin
      if (r_r == desc_r.row_hi) begin
        r_r <= desc_r.row_lo;
        c_r <= c_r + 3'd1;
      end else begin
        r_r <= r_r + 3'd1;
      end
    end
    if (emit) begin
      id_r   <= id_nxt;
      stat_r <= desc_r.status;
      last_r <= is_last;
    end
  end

  `ASSERT_IMPLY(a_col_range, clk, rst_n, busy_r && desc_r.status == ST_OK, c_r >= desc_r.col_lo && c_r <= desc_r.col_hi, "column walk left box")
  `ASSERT_IMPLY(a_row_range, clk, rst_n, busy_r && desc_r.status == ST_OK, r_r >= desc_r.row_lo && r_r <= desc_r.row_hi, "row walk left box")

endmodule

### dv/grid_cells_for_bounding_box_unit_tb.sv
// Self-checking testbench for the bounding box to grid cell enumeration unit.
`timescale 1ns / 100ps

module grid_cells_for_bounding_box_unit_tb;
  import gcbb_pkg::*;

  localparam int ONE = 65536;
  localparam int LIMIT = 400000;
  localparam int MAX_REPORTS = 50;
  localparam longint COORD_MAX = 64'sh7FFF_FFFF;
  localparam longint COORD_MIN = -64'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
  } box_t;

  typedef struct packed {
    logic [ID_W-1:0]   cell_id;
    logic [STAT_W-1:0] status;
    logic              is_last;
  } cell_hit_t;

  class cell_scoreboard;
    logic signed [COORD_W-1:0] org_x;
    logic signed [COORD_W-1:0] org_y;
    logic [SIZE_W-1:0]         size_w;
    logic [SIZE_W-1:0]         size_h;
    logic [CPD_W-1:0]          cpd;
    cell_hit_t                 cells_due[$];
    int                        errors;

    function new();
      org_x = 0;
      org_y = 0;
      size_w = 31'(ONE);
      size_h = 31'(ONE);
      cpd = 4'd8;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        CFG_ORIGIN_X:      org_x = d;
        CFG_ORIGIN_Y:      org_y = d;
        CFG_CELL_WIDTH:    size_w = d[SIZE_W-1:0];
        CFG_CELL_HEIGHT:   size_h = d[SIZE_W-1:0];
        CFG_CELLS_PER_DIM: cpd = d[CPD_W-1:0];
        default: ;
      endcase
    endfunction

    function bit locate(logic signed [31:0] coord, logic signed [31:0] org,
                        logic [SIZE_W-1:0] size, int p, output int idx);
      longint q;
      idx = 0;
      if (size == 0) return 0;
      q = (longint'(coord) - longint'(org)) / longint'(size);
      if (q < 0 || q >= p) return 0;
      idx = int'(q);
      return 1;
    endfunction

    function void enumerate_box(box_t b);
      int p, cl, ch, rl, rh;
      bit ok;
      cell_hit_t h;
      p = (cpd > MAX_CELLS_PER_DIM) ? MAX_CELLS_PER_DIM : int'(cpd);
      ok = locate(b.min_x, org_x, size_w, p, cl);
      ok = locate(b.min_y, org_y, size_h, p, rl) && ok;
      ok = locate(b.max_x, org_x, size_w, p, ch) && ok;
      ok = locate(b.max_y, org_y, size_h, p, rh) && ok;
      h.cell_id = '0;
      h.is_last = 1'b1;
      if (!ok) begin
        h.status = ST_OUTSIDE;
        cells_due.push_back(h);
      end else if (cl > ch || rl > rh) begin
        h.status = ST_EMPTY;
        cells_due.push_back(h);
      end else begin
        for (int c = cl; c <= ch; c++) begin
          for (int r = rl; r <= rh; r++) begin
            h.cell_id = ID_W'(c + r * p);
            h.status = ST_OK;
            h.is_last = (c == ch && r == rh);
            cells_due.push_back(h);
          end
        end
      end
    endfunction

    function void check_cell(cell_hit_t got);
      cell_hit_t want;
      if (cells_due.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: unexpected result cell_id %0d status %0d last %0d",
                   $time, got.cell_id, got.status, got.is_last);
        errors++;
        return;
      end
      want = cells_due.pop_front();
      if (got.cell_id !== want.cell_id) begin
        if (errors < MAX_REPORTS)
          $display("%0t: cell_id expected %0d actual %0d", $time, want.cell_id, got.cell_id);
        errors++;
      end
      if (got.status !== want.status) begin
        if (errors < MAX_REPORTS)
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.is_last !== want.is_last) begin
        if (errors < MAX_REPORTS)
          $display("%0t: last expected %0d actual %0d", $time, want.is_last, got.is_last);
        errors++;
      end
    endfunction

    function int pending();
      return cells_due.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = CFG_ORIGIN_X;
  logic [31:0]        cfg_wdata = '0;
  logic               push = 1'b0;
  logic               full;
  logic signed [31:0] in_box_min_x = '0;
  logic signed [31:0] in_box_min_y = '0;
  logic signed [31:0] in_box_max_x = '0;
  logic signed [31:0] in_box_max_y = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [5:0]         out_cell_id;
  logic [1:0]         out_status;
  logic               out_last;

  cell_scoreboard sb;
  gcbb_cfg_t      grid;
  int             idle_pct = 0;
  int             stall_pct = 0;
  int             cycles = 0;

  grid_cells_for_bounding_box_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .push         (push),
    .full         (full),
    .in_box_min_x (in_box_min_x),
    .in_box_min_y (in_box_min_y),
    .in_box_max_x (in_box_max_x),
    .in_box_max_y (in_box_max_y),
    .empty        (empty),
    .pop          (pop),
    .out_cell_id  (out_cell_id),
    .out_status   (out_status),
    .out_last     (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("grid_cells_for_bounding_box_unit_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    pop <= rst_n && ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we)
        sb.write_reg(cfg_index, cfg_wdata);
      if (push && !full)
        sb.enumerate_box({in_box_min_x, in_box_min_y, in_box_max_x, in_box_max_y});
      if (pop && !empty)
        sb.check_cell({out_cell_id, out_status, out_last});
    end
  end

  function automatic box_t mk_box(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                  logic [31:0] d);
    box_t x;
    x.min_x = a;
    x.min_y = b;
    x.max_x = c;
    x.max_y = d;
    return x;
  endfunction

  function automatic logic [31:0] coord_in(logic signed [31:0] org, logic [SIZE_W-1:0] size,
                                           int idx);
    longint v, frac;
    if (size == 0) return $urandom;
    frac = longint'($urandom_range(0, 32'(size) - 1));
    if (idx == 0 && $urandom_range(0, 3) == 0)
      v = longint'(org) - frac;
    else if (idx < 0)
      v = longint'(org) + longint'(idx) * longint'(size) - frac;
    else
      v = longint'(org) + longint'(idx) * longint'(size) + frac;
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return v[31:0];
  endfunction

  function automatic box_t make_box();
    int p, sel, cl, ch, rl, rh;
    p = (grid.cells_per_dim > MAX_CELLS_PER_DIM) ? MAX_CELLS_PER_DIM
                                                  : int'(grid.cells_per_dim);
    sel = $urandom_range(0, 99);
    if (p == 0 || sel >= 90)
      return mk_box($urandom, $urandom, $urandom, $urandom);
    cl = $urandom_range(0, p - 1);
    ch = $urandom_range(cl, p - 1);
    rl = $urandom_range(0, p - 1);
    rh = $urandom_range(rl, p - 1);
    if (sel >= 70 && sel < 80 && p > 1) begin
      if ($urandom_range(0, 1)) begin
        ch = $urandom_range(0, p - 2);
        cl = $urandom_range(ch + 1, p - 1);
      end else begin
        rh = $urandom_range(0, p - 2);
        rl = $urandom_range(rh + 1, p - 1);
      end
    end else if (sel >= 80) begin
      case ($urandom_range(0, 3))
        0: cl = -1 - int'($urandom_range(0, 2));
        1: rl = -1 - int'($urandom_range(0, 2));
        2: ch = p + int'($urandom_range(0, 2));
        default: rh = p + int'($urandom_range(0, 2));
      endcase
    end
    return mk_box(coord_in(grid.origin_x, grid.cell_width, cl),
                  coord_in(grid.origin_y, grid.cell_height, rl),
                  coord_in(grid.origin_x, grid.cell_width, ch),
                  coord_in(grid.origin_y, grid.cell_height, rh));
  endfunction

  task automatic configure(gcbb_cfg_t c);
    logic [31:0] junk;
    junk = $urandom;
    grid = c;
    cfg_we <= 1'b1;
    cfg_index <= CFG_ORIGIN_X;
    cfg_wdata <= c.origin_x;
    @(posedge clk);
    cfg_index <= CFG_ORIGIN_Y;
    cfg_wdata <= c.origin_y;
    @(posedge clk);
    cfg_index <= CFG_CELL_WIDTH;
    cfg_wdata <= {junk[31], c.cell_width};
    @(posedge clk);
    cfg_index <= CFG_CELL_HEIGHT;
    cfg_wdata <= {junk[30], c.cell_height};
    @(posedge clk);
    cfg_index <= CFG_CELLS_PER_DIM;
    cfg_wdata <= {junk[31:4], c.cells_per_dim};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_box(box_t b);
    while ($urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_box_min_x <= b.min_x;
    in_box_min_y <= b.min_y;
    in_box_max_x <= b.max_x;
    in_box_max_y <= b.max_y;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random(int n, int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++)
      send_box(make_box());
    drain();
  endtask

  initial begin
    box_t      directed[$];
    gcbb_cfg_t c;

    sb = new();
    grid = '{origin_x: 0, origin_y: 0, cell_width: 31'(ONE), cell_height: 31'(ONE),
             cells_per_dim: 4'd8};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(mk_box(0, 0, 0, 0));
    directed.push_back(mk_box(0, 0, 8 * ONE - 1, 8 * ONE - 1));
    directed.push_back(mk_box(7 * ONE, 7 * ONE, 7 * ONE, 7 * ONE));
    directed.push_back(mk_box(-1, -(ONE - 1), 0, 0));
    directed.push_back(mk_box(-ONE, 0, 0, 0));
    directed.push_back(mk_box(0, 0, 8 * ONE, 0));
    directed.push_back(mk_box(0, 0, 0, 8 * ONE));
    directed.push_back(mk_box(3 * ONE, 0, 2 * ONE, 0));
    directed.push_back(mk_box(0, 5 * ONE, 0, 4 * ONE));
    directed.push_back(mk_box(5 * ONE, 0, 2 * ONE, 9 * ONE));
    directed.push_back(mk_box(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    directed.push_back(mk_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    directed.push_back(mk_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    directed.push_back(mk_box(0, 0, 0, 32'hFFFF_FFFF));
    directed.push_back(mk_box(2 * ONE + 5, 3 * ONE, 4 * ONE + ONE / 2, 3 * ONE + 7));
    directed.push_back(mk_box(ONE, ONE, 6 * ONE, 2 * ONE));
    directed.push_back(mk_box(0, 7 * ONE, 7 * ONE + ONE - 1, 7 * ONE));
    foreach (directed[i])
      send_box(directed[i]);
    drain();

    send_random(30, 0, 0);

    configure('{origin_x: 32'(-(13 * ONE / 4)), origin_y: 32'(1000 * ONE),
                cell_width: 31'(7 * ONE / 2), cell_height: 31'(ONE / 4),
                cells_per_dim: 4'd5});
    send_random(40, 80, 0);

    configure('{origin_x: 32'h8000_0000, origin_y: 32'h7FFF_FFFF,
                cell_width: 31'h7FFF_FFFF, cell_height: 31'd1, cells_per_dim: 4'd1});
    send_random(30, 0, 80);

    c.origin_x = 32'($urandom_range(0, 200 * ONE)) - 32'(100 * ONE);
    c.origin_y = 32'($urandom_range(0, 200 * ONE)) - 32'(100 * ONE);
    c.cell_width = 31'($urandom_range(1, 4 * ONE));
    c.cell_height = 31'($urandom_range(1, 4 * ONE));
    c.cells_per_dim = 4'd15;
    configure(c);
    send_random(30, 12, 12);

    configure('{origin_x: 0, origin_y: 0, cell_width: 31'(ONE), cell_height: 31'(ONE),
                cells_per_dim: 4'd0});
    send_random(10, 12, 12);

    configure('{origin_x: 0, origin_y: 0, cell_width: 31'd0, cell_height: 31'(ONE),
                cells_per_dim: 4'd8});
    send_random(5, 0, 0);

    configure('{origin_x: 0, origin_y: 0, cell_width: 31'(ONE), cell_height: 31'd0,
                cells_per_dim: 4'd8});
    send_random(5, 0, 0);

    c.origin_x = $urandom;
    c.origin_y = $urandom;
    c.cell_width = 31'($urandom_range(1, 1 << 20));
    c.cell_height = 31'($urandom_range(1, 1 << 20));
    c.cells_per_dim = 4'($urandom_range(2, 7));
    configure(c);
    send_random(20, 0, 0);

    repeat (40) @(posedge clk);
    if (sb.errors == 0)
      $display("grid_cells_for_bounding_box_unit_tb: PASS");
    else
      $display("grid_cells_for_bounding_box_unit_tb: FAIL");
    $finish;
  end

endmodule
